### src/rct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rct_pkg;

  localparam int PFX_W      = 64;
  localparam int TIME_W     = 48;
  localparam int TTL_W      = 32;
  localparam int GEN_W      = 32;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int HASH_W     = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [TTL_W-1:0]  TTL_RESET = 32'd900000;

  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NOTE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL    = 1'b1;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MIX,
    HS_REDUCE,
    HS_DONE
  } hsh_state_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_EVAL,
    ST_WIPE,
    ST_OUT
  } rct_state_t;

  typedef struct packed {
    logic [PFX_W-1:0]  prefix;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, b};
    return x * FNV_PRIME;
  endfunction

endpackage

`default_nettype wire

### src/rct_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module rct_hash #(
  parameter int SLOT_COUNT = 8192,
  localparam int IDX_W = $clog2(SLOT_COUNT)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rct_pkg::PFX_W-1:0] prefix,
  output logic                           done,
  output logic [IDX_W-1:0]               slot
);

  import rct_pkg::*;

  localparam int MIX_STEPS = 8;
  localparam int RED_STEP  = HASH_W / MIX_STEPS;
  localparam int CNT_W     = $clog2(MIX_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MIX_STEPS - 1);
  localparam logic IS_POW2 = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);
  localparam logic [IDX_W:0] MODULUS = (IDX_W+1)'(SLOT_COUNT);

  hsh_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [HASH_W-1:0] h_r;
  logic [PFX_W-1:0]  pfx_r;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic              last_step;

  assign last_step = (cnt_r == CNT_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      HS_IDLE: begin
        if (start) state_nxt = HS_MIX;
      end
      HS_MIX: begin
        if (last_step) state_nxt = IS_POW2 ? HS_DONE : HS_REDUCE;
      end
      HS_REDUCE: begin
        if (last_step) state_nxt = HS_DONE;
      end
      HS_DONE: begin
        state_nxt = HS_IDLE;
      end
      default: state_nxt = HS_IDLE;
    endcase
  end

  // Restoring remainder, a few hash bits per cycle, most significant first.
  always_comb begin
    logic [IDX_W:0] t;
    rem_nxt = rem_r;
    for (int k = 0; k < RED_STEP; k++) begin
      t = {rem_nxt, h_r[HASH_W-1-k]};
      if (t >= MODULUS) t = t - MODULUS;
      rem_nxt = t[IDX_W-1:0];
    end
  end

  always_comb begin
    done = (state_r == HS_DONE);
    slot = IS_POW2 ? h_r[IDX_W-1:0] : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        HS_IDLE: begin
          cnt_r <= '0;
        end
        HS_MIX, HS_REDUCE: begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      HS_IDLE: begin
        if (start) begin
          h_r   <= FNV_BASIS;
          pfx_r <= prefix;
        end
      end
      HS_MIX: begin
        h_r   <= fnv_step(h_r, pfx_r[7:0]);
        pfx_r <= pfx_r >> 8;
        rem_r <= '0;
      end
      HS_REDUCE: begin
        rem_r <= rem_nxt;
        h_r   <= h_r << RED_STEP;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### src/reject_cache_ttl_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// One item at a time. A query runs the eight-step FNV loop, reads its slot and checks the entry;
// a note runs the same loop and writes its slot. The hash adds a remainder reduction when
// SLOT_COUNT is not a power of two. A clear zeroes every slot, one slot written per cycle.
// With enable 0, and for the unused function code, an item goes straight to its result beat.
// After reset the block sweeps all SLOT_COUNT slots to zero before it takes the first beat;
// configuration writes are taken during the sweep. Reset sets enable 1 and ttl_ms 900000.
module reject_cache_ttl_lookup_unit #(
  parameter int SLOT_COUNT = 8192
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rct_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rct_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [rct_pkg::PFX_W-1:0]      in_txid_prefix,
  input  wire logic [rct_pkg::TIME_W-1:0]     in_now_ms,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_seen,
  output logic [rct_pkg::GEN_W-1:0]           out_generation
);

  import rct_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  rct_state_t        state_r, state_nxt;
  logic              enable_r;
  logic [TTL_W-1:0]  ttl_r;
  logic [GEN_W-1:0]  gen_r;
  logic [FUNC_W-1:0] func_r;
  logic [PFX_W-1:0]  pfx_r;
  logic [TIME_W-1:0] now_r;
  logic [IDX_W-1:0]  clr_idx_r;
  logic              seen_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_seen_r;
  logic [GEN_W-1:0]  out_gen_r;

  entry_t            mem [SLOT_COUNT];
  entry_t            rd_r;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_waddr;
  logic              mem_we;
  logic              mem_re;

  logic              hash_start;
  logic              hash_done;
  logic [IDX_W-1:0]  hash_slot;

  logic              accept;
  logic              wipe_last;
  logic              out_free;
  logic              out_push;
  logic [TIME_W:0]   age;
  logic              fresh;
  logic              match;

  rct_hash #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .prefix(in_txid_prefix),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign wipe_last = (clr_idx_r == IDX_LAST);
  assign out_free  = !out_valid_r || !out_stall;

  assign age   = {1'b0, now_r} - {1'b0, rd_r.stamp};
  assign fresh = !age[TIME_W] && (age[TIME_W-1:0] <= {{(TIME_W-TTL_W){1'b0}}, ttl_r});
  assign match = (rd_r.prefix == pfx_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (wipe_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (!enable_r) begin
            state_nxt = ST_OUT;
          end else begin
            unique case (in_func) inside
              FUNC_QUERY, FUNC_NOTE: state_nxt = ST_HASH;
              FUNC_CLEAR:            state_nxt = ST_WIPE;
              default:               state_nxt = ST_OUT;
            endcase
          end
        end
      end
      ST_HASH: begin
        if (hash_done) state_nxt = (func_r == FUNC_NOTE) ? ST_OUT : ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_OUT;
      end
      ST_WIPE: begin
        if (wipe_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    hash_start = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = clr_idx_r;
    mem_wdata  = '0;
    out_push   = 1'b0;
    unique case (state_r)
      ST_INIT, ST_WIPE: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        hash_start = accept && enable_r && ((in_func == FUNC_QUERY) || (in_func == FUNC_NOTE));
      end
      ST_HASH: begin
        if (hash_done) begin
          if (func_r == FUNC_NOTE) begin
            mem_we    = 1'b1;
            mem_waddr = hash_slot;
            mem_wdata = '{prefix: pfx_r, stamp: now_r};
          end else begin
            mem_re = 1'b1;
          end
        end
      end
      ST_OUT: begin
        out_push = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      enable_r    <= 1'b1;
      ttl_r       <= TTL_RESET;
      gen_r       <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE: enable_r <= cfg_wdata[0];
          CFG_TTL:    ttl_r    <= cfg_wdata[TTL_W-1:0];
          default: begin
          end
        endcase
      end
      if ((state_r == ST_INIT) || (state_r == ST_WIPE)) begin
        clr_idx_r <= wipe_last ? '0 : clr_idx_r + IDX_W'(1);
      end
      if (accept && enable_r && (in_func == FUNC_CLEAR)) begin
        gen_r <= gen_r + GEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      pfx_r  <= in_txid_prefix;
      now_r  <= in_now_ms;
      seen_r <= 1'b0;
    end else if (state_r == ST_EVAL) begin
      seen_r <= match && fresh;
    end
    if (out_push) begin
      out_seen_r <= seen_r;
      out_gen_r  <= gen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_r <= mem[hash_slot];
  end

  assign out_valid      = out_valid_r;
  assign out_seen       = out_seen_r;
  assign out_generation = out_gen_r;

endmodule

`default_nettype wire

### test/reject_cache_ttl_lookup_checker.sv
`timescale 1ns / 1ps

module reject_cache_ttl_lookup_checker #(
  parameter int SLOTS = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rct_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [rct_pkg::FUNC_W-1:0]     in_func,
  input  logic [rct_pkg::PFX_W-1:0]      in_txid_prefix,
  input  logic [rct_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_seen,
  input  logic [rct_pkg::GEN_W-1:0]      out_generation,
  output int                             mismatch_count,
  output int                             answers_open
);
  import rct_pkg::*;

  typedef struct packed {
    logic             seen;
    logic [GEN_W-1:0] generation;
  } answer_t;

  logic [PFX_W-1:0]  prefix_store [SLOTS];
  logic [TIME_W-1:0] stamp_store [SLOTS];
  logic [GEN_W-1:0]  clear_count;
  logic              feature_on;
  logic [TTL_W-1:0]  ttl_ms;
  answer_t           answers_due [$];

  function automatic int unsigned cache_slot(input logic [PFX_W-1:0] p);
    logic [HASH_W-1:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < 8; i++) h = (h ^ HASH_W'(p[8*i +: 8])) * FNV_PRIME;
    return h % SLOTS;
  endfunction

  task automatic wipe_store();
    for (int i = 0; i < SLOTS; i++) begin
      prefix_store[i] = '0;
      stamp_store[i] = '0;
    end
  endtask

  task automatic lookup_and_record(input logic [FUNC_W-1:0] f, input logic [PFX_W-1:0] p,
                                   input logic [TIME_W-1:0] t);
    answer_t     a;
    int unsigned s;
    a.seen = 1'b0;
    s = cache_slot(p);
    if (feature_on) begin
      case (f)
        FUNC_QUERY: begin
          a.seen = prefix_store[s] == p && stamp_store[s] <= t &&
                   (t - stamp_store[s]) <= TIME_W'(ttl_ms);
        end
        FUNC_NOTE: begin
          prefix_store[s] = p;
          stamp_store[s] = t;
        end
        FUNC_CLEAR: begin
          wipe_store();
          clear_count = clear_count + 1'b1;
        end
        default: begin
        end
      endcase
    end
    a.generation = clear_count;
    answers_due.push_back(a);
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      wipe_store();
      clear_count = '0;
      feature_on = 1'b1;
      ttl_ms = TTL_RESET;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLE) begin
          feature_on = cfg_wdata[0];
        end else if (cfg_index == CFG_TTL) begin
          ttl_ms = cfg_wdata[TTL_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        lookup_and_record(in_func, in_txid_prefix, in_now_ms);
      end
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $error("result beat with no answer waiting: seen %0d, generation %0d",
                 out_seen, out_generation);
          mismatch_count++;
        end else begin
          want = answers_due.pop_front();
          if (out_seen !== want.seen) begin
            $error("seen: expected %0d, actual %0d", want.seen, out_seen);
            mismatch_count++;
          end
          if (out_generation !== want.generation) begin
            $error("generation: expected %0d, actual %0d", want.generation, out_generation);
            mismatch_count++;
          end
        end
      end
    end
    answers_open <= answers_due.size();
  end

endmodule

### test/reject_cache_ttl_lookup_unit_test.sv
`timescale 1ns / 1ps

module reject_cache_ttl_lookup_unit_test;
  import rct_pkg::*;

  localparam int SLOTS = 8192;
  localparam int HOT = 8;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic [FUNC_W-1:0]     in_func = '0;
  logic [PFX_W-1:0]      in_txid_prefix = '0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_seen;
  logic [GEN_W-1:0]      out_generation;

  int                    mismatch_count;
  int                    answers_open;
  int                    idle_pct = 0;
  int                    stall_pct = 0;
  bit                    want_hold = 1'b0;
  bit                    hold_taken = 1'b0;
  int                    hold_left = 0;
  int                    quiet_cycles = 0;
  int unsigned           step_ms = 1;
  logic [TIME_W-1:0]     clock_ms = 48'd10000;
  logic [PFX_W-1:0]      hot [HOT];
  logic [PFX_W-1:0]      twin [HOT];

  reject_cache_ttl_lookup_unit #(.SLOT_COUNT(SLOTS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_txid_prefix(in_txid_prefix), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_seen(out_seen), .out_generation(out_generation)
  );

  reject_cache_ttl_lookup_checker #(.SLOTS(SLOTS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_txid_prefix(in_txid_prefix), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_seen(out_seen), .out_generation(out_generation),
    .mismatch_count(mismatch_count), .answers_open(answers_open)
  );

  always #2 clk = ~clk;

  // The long hold-off lets the block fill up while the sender keeps offering beats.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= $urandom_range(1, 100) <= stall_pct;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned slot_index(input logic [PFX_W-1:0] p);
    logic [HASH_W-1:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < 8; i++) h = (h ^ HASH_W'(p[8*i +: 8])) * FNV_PRIME;
    return h % SLOTS;
  endfunction

  function automatic logic [PFX_W-1:0] find_twin(input logic [PFX_W-1:0] p);
    logic [PFX_W-1:0] q;
    int unsigned      s;
    s = slot_index(p);
    do q = {$urandom, $urandom}; while (q == p || slot_index(q) != s);
    return q;
  endfunction

  function automatic logic [PFX_W-1:0] pick_prefix();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return hot[$urandom_range(0, HOT - 1)];
    if (roll < 75) return twin[$urandom_range(0, HOT - 1)];
    if (roll < 85) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, step_ms);
    if (roll < 80) return clock_ms;
    if (roll < 90) return clock_ms - $urandom_range(0, step_ms);
    if (roll < 95) return TIME_W'($urandom_range(0, 2000));
    return {16'($urandom), $urandom};
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [PFX_W-1:0] p,
                           input logic [TIME_W-1:0] t);
    while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_txid_prefix <= p;
    in_now_ms <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned       roll;
    logic [FUNC_W-1:0] f;
    roll = $urandom_range(0, 999);
    if (roll < 15) f = FUNC_CLEAR;
    else if (roll < 45) f = FUNC_UNUSED;
    else if (roll < 500) f = FUNC_QUERY;
    else f = FUNC_NOTE;
    send_item(f, pick_prefix(), pick_time());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_open != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic [TTL_W-1:0] ttl);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_wdata <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_index <= CFG_TTL;
    cfg_wdata <= ttl;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic             en;
    logic [TTL_W-1:0] ttl;
    for (int i = 0; i < HOT; i++) begin
      hot[i] = {$urandom, $urandom};
      twin[i] = find_twin(hot[i]);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(1'b1, 32'd1000);
    send_item(FUNC_QUERY, '0, 48'd0);
    send_item(FUNC_QUERY, '0, 48'd1000);
    send_item(FUNC_QUERY, '0, 48'd1001);
    send_item(FUNC_QUERY, '1, 48'd0);
    send_item(FUNC_NOTE, hot[0], 48'd5000);
    send_item(FUNC_QUERY, hot[0], 48'd5000);
    send_item(FUNC_QUERY, hot[0], 48'd6000);
    send_item(FUNC_QUERY, hot[0], 48'd6001);
    send_item(FUNC_QUERY, hot[0], 48'd4999);
    send_item(FUNC_NOTE, '1, '1);
    send_item(FUNC_QUERY, '1, '1);
    send_item(FUNC_UNUSED, hot[1], '1);
    send_item(FUNC_QUERY, hot[1], '1);
    send_item(FUNC_NOTE, twin[0], 48'd5000);
    send_item(FUNC_QUERY, hot[0], 48'd5000);
    send_item(FUNC_QUERY, twin[0], 48'd5000);
    send_item(FUNC_CLEAR, '1, '1);
    send_item(FUNC_QUERY, '0, 48'd10);
    drain();
    set_config(1'b0, 32'd1000);
    send_item(FUNC_NOTE, hot[2], 48'd100);
    send_item(FUNC_QUERY, '0, 48'd10);
    send_item(FUNC_CLEAR, '0, '0);
    drain();
    set_config(1'b1, 32'd0);
    send_item(FUNC_QUERY, hot[2], 48'd100);
    send_item(FUNC_QUERY, '0, 48'd0);
    send_item(FUNC_QUERY, '0, 48'd1);
    drain();
    set_config(1'b1, '1);
    send_item(FUNC_NOTE, hot[3], 48'd0);
    send_item(FUNC_QUERY, hot[3], 48'hFFFF_FFFF);
    send_item(FUNC_QUERY, hot[3], 48'h1_0000_0000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ttl = 32'd1000;
        1: ttl = $urandom_range(1, 5000);
        2: ttl = '0;
        3: ttl = '1;
        4: ttl = 32'd500;
        5: ttl = TTL_RESET;
        6: ttl = $urandom_range(1, 64);
        default: ttl = $urandom;
      endcase
      en = ph != 4;
      idle_pct = (ph % 4 == 1) ? 57 : (ph % 4 == 3) ? 29 : 0;
      stall_pct = (ph % 4 == 2) ? 57 : (ph % 4 == 3) ? 29 : 0;
      step_ms = (ttl > 4000) ? 2000 : ttl / 4 + 1;
      set_config(en, ttl);
      if (ph == 0) want_hold <= 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && answers_open == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
src/rct_pkg.sv
src/rct_hash.sv
src/reject_cache_ttl_lookup_unit.sv
test/reject_cache_ttl_lookup_checker.sv
test/reject_cache_ttl_lookup_unit_test.sv
